// File: design/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared definitions for the chained hash table engine
// Request and status codes, datapath micro-operations and the status bundle
// returned from the datapath to the controller.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int STORE_ENTRIES_DEF = 32;
    localparam int HOME_SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF      = 32;

    localparam int REQ_W    = 2;
    localparam int GENRE_W  = 5;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_CUR,
        OP_ADVANCE,
        OP_WR_HOME,
        OP_RD_FRESH,
        OP_TAKE_FRESH,
        OP_APPEND,
        OP_CLR_HEAD,
        OP_RD_SUCC,
        OP_PULL_UP,
        OP_UNLINK,
        OP_RELEASE
    } t_dp_op;

    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic is_search;
        logic unknown;
        logic cur_valid;
        logic free_null;
        logic match;
        logic link_null;
        logic step_last;
        logic prev_null;
        logic clear_last;
    } t_dp_status;

endpackage

// File: design/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine: chained hash table in a fixed entry store
// Insert, delete and search requests on home slots with overflow chains.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A request ends
// without touching the store, ends at the home slot, or, for a delete, pulls
// a successor up into the home slot and releases it. Each chain link walked
// adds a read: the single read port of the entry store is visited once per
// link. An insert into an occupied bucket takes a fresh entry and walks to
// the chain end to append it; a search or a failed lookup walks until a
// match or the chain end; a delete further down walks to its match, unlinks
// it and releases it. After reset a clearing pass over every entry
// initialises the link store and free list, stalling requests. A finished
// result waits in the output register while the next request is taken.
module chained_hash_table_engine #(
    parameter int STORE_ENTRIES = chte_pkg::STORE_ENTRIES_DEF,
    parameter int HOME_SLOTS    = chte_pkg::HOME_SLOTS_DEF,
    parameter int KEY_BITS      = chte_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [chte_pkg::REQ_W-1:0]    i_req_type,
    input  logic [chte_pkg::GENRE_W-1:0]  i_genre_code,
    input  logic [chte_pkg::ID_W-1:0]     i_title_id,
    input  logic [chte_pkg::ID_W-1:0]     i_artist_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [chte_pkg::STATUS_W-1:0] o_status
);

    chte_pkg::t_dp_op     w_op;
    chte_pkg::t_dp_status w_dp_status;

    chte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_found  (o_found),
        .o_status (o_status),
        .i_dp     (w_dp_status),
        .o_op     (w_op)
    );

    chte_datapath #(
        .STORE_ENTRIES (STORE_ENTRIES),
        .HOME_SLOTS    (HOME_SLOTS),
        .KEY_BITS      (KEY_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_req_type   (i_req_type),
        .i_genre_code (i_genre_code),
        .i_title_id   (i_title_id),
        .i_artist_id  (i_artist_id),
        .o_status     (w_dp_status)
    );

endmodule

// File: design/chte_datapath.sv
// ----------------------------------------------------------------------------
// chte_datapath: entry store, free list and chain walk registers
// Holds the key and link memories, executes one micro-operation a cycle and
// reports the flags the controller branches on.
// ----------------------------------------------------------------------------
module chte_datapath #(
    parameter int STORE_ENTRIES = chte_pkg::STORE_ENTRIES_DEF,
    parameter int HOME_SLOTS    = chte_pkg::HOME_SLOTS_DEF,
    parameter int KEY_BITS      = chte_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  chte_pkg::t_dp_op             i_op,
    input  logic [chte_pkg::REQ_W-1:0]   i_req_type,
    input  logic [chte_pkg::GENRE_W-1:0] i_genre_code,
    input  logic [chte_pkg::ID_W-1:0]    i_title_id,
    input  logic [chte_pkg::ID_W-1:0]    i_artist_id,
    output chte_pkg::t_dp_status         o_status
);

    localparam int LINK_W = $clog2(STORE_ENTRIES + 1);
    localparam int IDX_W  = $clog2(STORE_ENTRIES);
    localparam int KEY_W  = (KEY_BITS < chte_pkg::ID_W) ? KEY_BITS : chte_pkg::ID_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(STORE_ENTRIES);
    localparam logic [LINK_W-1:0] FREE_INIT =
        (HOME_SLOTS < STORE_ENTRIES) ? LINK_W'(HOME_SLOTS) : LINK_NULL;
    localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(STORE_ENTRIES - 1);

    typedef struct packed {
        logic              valid;
        logic [LINK_W-1:0] link;
    } t_meta;

    typedef struct packed {
        logic [KEY_W-1:0] title;
        logic [KEY_W-1:0] artist;
    } t_key;

    t_meta r_meta_mem [STORE_ENTRIES];
    t_key  r_key_mem  [STORE_ENTRIES];

    logic [chte_pkg::REQ_W-1:0]   r_req;
    logic [chte_pkg::GENRE_W-1:0] r_code;
    logic [KEY_W-1:0]             r_title;
    logic [KEY_W-1:0]             r_artist;
    logic [LINK_W-1:0]            r_cur;
    logic [LINK_W-1:0]            r_prev;
    logic                         r_prev_valid;
    logic [LINK_W-1:0]            r_steps;
    logic [LINK_W-1:0]            r_free;
    logic [LINK_W-1:0]            r_fresh;
    logic [LINK_W-1:0]            r_rel;
    logic [IDX_W-1:0]             r_clr;

    logic                         r_rd_valid;
    logic [LINK_W-1:0]            r_rd_link;
    logic [KEY_W-1:0]             r_rd_title;
    logic [KEY_W-1:0]             r_rd_artist;

    logic                         w_meta_we;
    logic [IDX_W-1:0]             w_meta_addr;
    t_meta                        w_meta_wdata;
    logic                         w_key_we;
    logic [IDX_W-1:0]             w_key_addr;
    t_key                         w_key_wdata;
    logic                         w_rd_en;
    logic [IDX_W-1:0]             w_rd_addr;
    logic [LINK_W-1:0]            w_clr_next;
    logic [LINK_W-1:0]            w_clr_link;

    function automatic logic f_is_null(input logic [LINK_W-1:0] link);
        return link >= LINK_NULL;
    endfunction

    assign w_clr_next = LINK_W'(r_clr) + LINK_W'(1);
    assign w_clr_link = (32'(r_clr) < HOME_SLOTS || w_clr_next >= LINK_NULL) ?
                        LINK_NULL : w_clr_next;

    always_comb begin
        w_meta_we    = 1'b0;
        w_meta_addr  = r_cur[IDX_W-1:0];
        w_meta_wdata = '{valid: 1'b0, link: LINK_NULL};
        w_key_we     = 1'b0;
        w_key_addr   = r_cur[IDX_W-1:0];
        w_key_wdata  = '{title: r_title, artist: r_artist};
        w_rd_en      = 1'b0;
        w_rd_addr    = r_cur[IDX_W-1:0];
        case (i_op)
            chte_pkg::OP_CLEAR: begin
                w_meta_we    = 1'b1;
                w_meta_addr  = r_clr;
                w_meta_wdata = '{valid: 1'b0, link: w_clr_link};
            end
            chte_pkg::OP_RD_CUR: begin
                w_rd_en = 1'b1;
            end
            chte_pkg::OP_ADVANCE: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_rd_link[IDX_W-1:0];
            end
            chte_pkg::OP_WR_HOME: begin
                w_meta_we    = 1'b1;
                w_meta_wdata = '{valid: 1'b1, link: r_rd_link};
                w_key_we     = 1'b1;
            end
            chte_pkg::OP_RD_FRESH: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_free[IDX_W-1:0];
            end
            chte_pkg::OP_TAKE_FRESH: begin
                w_meta_we    = 1'b1;
                w_meta_addr  = r_free[IDX_W-1:0];
                w_meta_wdata = '{valid: 1'b1, link: LINK_NULL};
                w_key_we     = 1'b1;
                w_key_addr   = r_free[IDX_W-1:0];
                w_rd_en      = 1'b1;
            end
            chte_pkg::OP_APPEND: begin
                w_meta_we    = 1'b1;
                w_meta_wdata = '{valid: r_rd_valid, link: r_fresh};
            end
            chte_pkg::OP_CLR_HEAD: begin
                w_meta_we    = 1'b1;
                w_meta_wdata = '{valid: 1'b0, link: r_rd_link};
            end
            chte_pkg::OP_RD_SUCC: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_rd_link[IDX_W-1:0];
            end
            chte_pkg::OP_PULL_UP: begin
                w_meta_we    = 1'b1;
                w_meta_wdata = '{valid: 1'b1, link: r_rd_link};
                w_key_we     = 1'b1;
                w_key_wdata  = '{title: r_rd_title, artist: r_rd_artist};
            end
            chte_pkg::OP_UNLINK: begin
                w_meta_we    = 1'b1;
                w_meta_addr  = r_prev[IDX_W-1:0];
                w_meta_wdata = '{valid: r_prev_valid, link: r_rd_link};
            end
            chte_pkg::OP_RELEASE: begin
                w_meta_we    = 1'b1;
                w_meta_addr  = r_rel[IDX_W-1:0];
                w_meta_wdata = '{valid: 1'b0, link: r_free};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_meta_addr] <= w_meta_wdata;
        end
        if (w_key_we) begin
            r_key_mem[w_key_addr] <= w_key_wdata;
        end
        if (w_rd_en) begin
            r_rd_valid  <= r_meta_mem[w_rd_addr].valid;
            r_rd_link   <= r_meta_mem[w_rd_addr].link;
            r_rd_title  <= r_key_mem[w_rd_addr].title;
            r_rd_artist <= r_key_mem[w_rd_addr].artist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= FREE_INIT;
            r_clr  <= '0;
        end else begin
            case (i_op)
                chte_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                end
                chte_pkg::OP_LOAD: begin
                    r_req    <= i_req_type;
                    r_code   <= i_genre_code;
                    r_title  <= i_title_id[KEY_W-1:0];
                    r_artist <= i_artist_id[KEY_W-1:0];
                    r_cur    <= LINK_W'(i_genre_code);
                    r_prev   <= LINK_NULL;
                    r_steps  <= '0;
                end
                chte_pkg::OP_ADVANCE: begin
                    r_prev       <= r_cur;
                    r_prev_valid <= r_rd_valid;
                    r_cur        <= r_rd_link;
                    r_steps      <= r_steps + LINK_W'(1);
                end
                chte_pkg::OP_TAKE_FRESH: begin
                    r_fresh <= r_free;
                    r_free  <= r_rd_link;
                end
                chte_pkg::OP_RD_SUCC: begin
                    r_rel <= r_rd_link;
                end
                chte_pkg::OP_UNLINK: begin
                    r_rel <= r_cur;
                end
                chte_pkg::OP_RELEASE: begin
                    r_free <= r_rel;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_status.is_insert  = (r_req == chte_pkg::REQ_INSERT);
        o_status.is_delete  = (r_req == chte_pkg::REQ_DELETE);
        o_status.is_search  = (r_req == chte_pkg::REQ_SEARCH);
        o_status.unknown    = (32'(r_code) >= HOME_SLOTS) || (32'(r_code) >= STORE_ENTRIES);
        o_status.cur_valid  = r_rd_valid;
        o_status.free_null  = f_is_null(r_free);
        o_status.match      = r_rd_valid && (r_rd_title == r_title)
                              && (r_rd_artist == r_artist);
        o_status.link_null  = f_is_null(r_rd_link);
        o_status.step_last  = (r_steps == LINK_NULL);
        o_status.prev_null  = f_is_null(r_prev);
        o_status.clear_last = (r_clr == CLR_LAST);
    end

endmodule

// File: design/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl: request sequencer for the chained hash table engine
// Steps each request through the datapath and holds the result register.
// ----------------------------------------------------------------------------
module chte_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [chte_pkg::STATUS_W-1:0] o_status,
    input  chte_pkg::t_dp_status          i_dp,
    output chte_pkg::t_dp_op              o_op
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_HOME,
        ST_INS_FRESH,
        ST_INS_WALK,
        ST_EVAL,
        ST_PULL,
        ST_RELEASE,
        ST_DONE
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic                          r_res_found;
    logic                          n_res_found;
    logic [chte_pkg::STATUS_W-1:0] r_res_status;
    logic [chte_pkg::STATUS_W-1:0] n_res_status;
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [chte_pkg::STATUS_W-1:0] r_out_status;
    logic                          w_out_load;

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_status = r_out_status;

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state      = r_state;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        o_op         = chte_pkg::OP_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_op = chte_pkg::OP_CLEAR;
                if (i_dp.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_op    = chte_pkg::OP_LOAD;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!(i_dp.is_insert || i_dp.is_delete || i_dp.is_search)) begin
                    n_res_found  = 1'b0;
                    n_res_status = chte_pkg::STATUS_DONE;
                    n_state      = ST_DONE;
                end else if (i_dp.unknown) begin
                    n_res_found  = 1'b0;
                    n_res_status = chte_pkg::STATUS_UNKNOWN;
                    n_state      = ST_DONE;
                end else begin
                    o_op    = chte_pkg::OP_RD_CUR;
                    n_state = i_dp.is_insert ? ST_INS_HOME : ST_EVAL;
                end
            end
            ST_INS_HOME: begin
                n_res_found = 1'b0;
                if (!i_dp.cur_valid) begin
                    o_op         = chte_pkg::OP_WR_HOME;
                    n_res_status = chte_pkg::STATUS_DONE;
                    n_state      = ST_DONE;
                end else if (i_dp.free_null) begin
                    n_res_status = chte_pkg::STATUS_FULL;
                    n_state      = ST_DONE;
                end else begin
                    o_op    = chte_pkg::OP_RD_FRESH;
                    n_state = ST_INS_FRESH;
                end
            end
            ST_INS_FRESH: begin
                o_op    = chte_pkg::OP_TAKE_FRESH;
                n_state = ST_INS_WALK;
            end
            ST_INS_WALK: begin
                if (i_dp.link_null || i_dp.step_last) begin
                    o_op         = chte_pkg::OP_APPEND;
                    n_res_status = chte_pkg::STATUS_DONE;
                    n_state      = ST_DONE;
                end else begin
                    o_op = chte_pkg::OP_ADVANCE;
                end
            end
            ST_EVAL: begin
                if (i_dp.match) begin
                    n_res_found  = 1'b1;
                    n_res_status = chte_pkg::STATUS_DONE;
                    if (i_dp.is_search) begin
                        n_state = ST_DONE;
                    end else if (!i_dp.prev_null) begin
                        o_op    = chte_pkg::OP_UNLINK;
                        n_state = ST_RELEASE;
                    end else if (i_dp.link_null) begin
                        o_op    = chte_pkg::OP_CLR_HEAD;
                        n_state = ST_DONE;
                    end else begin
                        o_op    = chte_pkg::OP_RD_SUCC;
                        n_state = ST_PULL;
                    end
                end else if (i_dp.link_null || i_dp.step_last) begin
                    n_res_found  = 1'b0;
                    n_res_status = chte_pkg::STATUS_NO_MATCH;
                    n_state      = ST_DONE;
                end else begin
                    o_op = chte_pkg::OP_ADVANCE;
                end
            end
            ST_PULL: begin
                o_op    = chte_pkg::OP_PULL_UP;
                n_state = ST_RELEASE;
            end
            ST_RELEASE: begin
                o_op    = chte_pkg::OP_RELEASE;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_found  <= n_res_found;
            r_res_status <= n_res_status;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= r_res_found;
                r_out_status <= r_res_status;
            end
        end
    end

endmodule

// File: verif/chained_hash_table_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_test: request-level test of the chained hash table
// Drives insert, delete and search requests through the valid/stall channels.
// A shadow copy of the entry store, its links and the free list predicts each
// found/status result. Covers unknown genres, the spare request code, chain
// growth up to a full table, head pull-up and unlinks, plus random back-pressure
// and a long output hold-off.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_test;
    import chte_pkg::*;

    localparam int STORE_ENTRIES = STORE_ENTRIES_DEF;
    localparam int HOME_SLOTS    = HOME_SLOTS_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int TAIL_CYCLES   = 40;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam logic [5:0] LINK_NULL = 6'(STORE_ENTRIES);

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [REQ_W-1:0]    i_req_type;
    logic [GENRE_W-1:0]  i_genre_code;
    logic [ID_W-1:0]     i_title_id;
    logic [ID_W-1:0]     i_artist_id;
    logic                o_valid;
    logic                i_stall;
    logic                o_found;
    logic [STATUS_W-1:0] o_status;

    // shadow copy of the entry store
    logic            slot_valid  [STORE_ENTRIES];
    logic [ID_W-1:0] slot_title  [STORE_ENTRIES];
    logic [ID_W-1:0] slot_artist [STORE_ENTRIES];
    logic [5:0]      slot_link   [STORE_ENTRIES];
    logic [5:0]      free_head;

    t_outcome expected_outcomes[$];
    int       fail_count    = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       holdoff_left  = 0;

    chained_hash_table_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_genre_code (i_genre_code),
        .i_title_id   (i_title_id),
        .i_artist_id  (i_artist_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_found      (o_found),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, or a counted hold-off when one is pending
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                i_stall <= 1'b1;
                holdoff_left = holdoff_left - 1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: found %0d status %0d", o_found, o_status);
                fail_count++;
            end else begin
                exp_res = expected_outcomes.pop_front();
                if (o_found !== exp_res.found) begin
                    $error("found mismatch: expected %0d, got %0d", exp_res.found, o_found);
                    fail_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    function automatic void free_entry(input int unsigned idx);
        slot_valid[idx] = 1'b0;
        slot_link[idx]  = free_head;
        free_head       = 6'(idx);
    endfunction

    function automatic t_outcome song_table_apply(
        input logic [REQ_W-1:0]   kind,
        input logic [GENRE_W-1:0] genre,
        input logic [ID_W-1:0]    title,
        input logic [ID_W-1:0]    artist
    );
        t_outcome    res;
        int unsigned cur;
        int unsigned prev;
        int unsigned fresh;
        int unsigned succ;
        int unsigned steps;
        bit          hit;
        res.found  = 1'b0;
        res.status = STATUS_DONE;
        hit        = 1'b0;
        if (kind == REQ_SPARE) begin
            res.status = STATUS_DONE;
        end else if (genre >= HOME_SLOTS) begin
            res.status = STATUS_UNKNOWN;
        end else if (kind == REQ_INSERT) begin
            if (!slot_valid[genre]) begin
                slot_valid[genre]  = 1'b1;
                slot_title[genre]  = title;
                slot_artist[genre] = artist;
            end else if (free_head >= STORE_ENTRIES) begin
                res.status = STATUS_FULL;
            end else begin
                fresh              = 32'(free_head);
                free_head          = slot_link[fresh];
                slot_valid[fresh]  = 1'b1;
                slot_title[fresh]  = title;
                slot_artist[fresh] = artist;
                slot_link[fresh]   = LINK_NULL;
                cur = 32'(genre);
                for (steps = 0; steps < STORE_ENTRIES && slot_link[cur] < STORE_ENTRIES;
                     steps++)
                    cur = 32'(slot_link[cur]);
                slot_link[cur] = 6'(fresh);
            end
        end else begin
            cur  = 32'(genre);
            prev = STORE_ENTRIES;
            for (steps = 0; steps < STORE_ENTRIES && cur < STORE_ENTRIES; steps++) begin
                if (slot_valid[cur] && slot_title[cur] == title
                    && slot_artist[cur] == artist) begin
                    hit = 1'b1;
                    break;
                end
                prev = cur;
                cur  = 32'(slot_link[cur]);
            end
            if (!hit) begin
                res.status = STATUS_NO_MATCH;
            end else begin
                res.found = 1'b1;
                if (kind == REQ_DELETE) begin
                    if (prev >= STORE_ENTRIES) begin
                        succ = 32'(slot_link[cur]);
                        if (succ >= STORE_ENTRIES) begin
                            slot_valid[cur] = 1'b0;
                        end else begin
                            // head takes over its successor
                            slot_title[cur]  = slot_title[succ];
                            slot_artist[cur] = slot_artist[succ];
                            slot_link[cur]   = slot_link[succ];
                            free_entry(succ);
                        end
                    end else begin
                        slot_link[prev] = slot_link[cur];
                        free_entry(cur);
                    end
                end
            end
        end
        return res;
    endfunction

    // called and returning at a falling edge; valid stays high between back-to-back requests
    task automatic send_request(
        input logic [REQ_W-1:0]   kind,
        input logic [GENRE_W-1:0] genre,
        input logic [ID_W-1:0]    title,
        input logic [ID_W-1:0]    artist
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_genre_code <= genre;
        i_title_id   <= title;
        i_artist_id  <= artist;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        expected_outcomes.push_back(song_table_apply(kind, genre, title, artist));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 27;
        recv_idle_pct = 81;
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_INSERT, 5'd16, 32'h1234, 32'h5678);
        send_request(REQ_DELETE, 5'd16, 32'h1234, 32'h5678);
        send_request(REQ_SEARCH, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_SPARE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_SPARE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 5'd0, 32'h0, 32'h0);
        send_request(REQ_INSERT, 5'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 5'd0, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_INSERT, 5'd0, 32'h0, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 5'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_DELETE, 5'd0, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    // one bucket grows until the free list runs dry, then is emptied again
    task automatic test_full_bucket();
        logic [GENRE_W-1:0] bucket;
        logic [ID_W-1:0]    titles  [18];
        logic [ID_W-1:0]    artists [18];
        logic [ID_W-1:0]    tmp;
        int                 i;
        int                 j;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bucket = 5'($urandom_range(0, HOME_SLOTS - 1));
        for (i = 0; i < 18; i++) begin
            titles[i]  = $urandom;
            artists[i] = $urandom;
            send_request(REQ_INSERT, bucket, titles[i], artists[i]);
        end
        send_request(REQ_SEARCH, bucket, titles[16], artists[16]);
        send_request(REQ_SEARCH, bucket, titles[16], ~artists[16]);
        for (i = 17; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = titles[i];  titles[i]  = titles[j];  titles[j]  = tmp;
            tmp = artists[i]; artists[i] = artists[j]; artists[j] = tmp;
        end
        for (i = 0; i < 18; i++)
            send_request(REQ_DELETE, bucket, titles[i], artists[i]);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        logic [ID_W-1:0]    title_pool  [6];
        logic [ID_W-1:0]    artist_pool [4];
        logic [REQ_W-1:0]   kind;
        logic [GENRE_W-1:0] genre;
        logic [ID_W-1:0]    title;
        logic [ID_W-1:0]    artist;
        int                 roll;
        int                 n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (title_pool[k])
            title_pool[k] = $urandom;
        foreach (artist_pool[k])
            artist_pool[k] = $urandom;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                kind = REQ_INSERT;
            else if (roll < 65)
                kind = REQ_DELETE;
            else if (roll < 95)
                kind = REQ_SEARCH;
            else
                kind = REQ_SPARE;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                genre = 5'($urandom_range(0, 3));
            else if (roll < 95)
                genre = 5'($urandom_range(0, HOME_SLOTS - 1));
            else
                genre = 5'($urandom_range(HOME_SLOTS, 31));
            if ($urandom_range(0, 9) == 0) begin
                title  = $urandom;
                artist = $urandom;
            end else begin
                title  = title_pool[$urandom_range(0, 5)];
                artist = artist_pool[$urandom_range(0, 3)];
            end
            send_request(kind, genre, title, artist);
        end
        wait_for_results();
    endtask

    // output held off long enough for the engine to fill and stall its input
    task automatic test_output_holdoff();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_left  = 150;
        for (n = 0; n < 12; n++)
            send_request(n % 3 == 0 ? REQ_INSERT : REQ_SEARCH,
                         5'($urandom_range(0, 3)), 32'($urandom_range(0, 3)), 32'h1);
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            slot_valid[i]  = 1'b0;
            slot_title[i]  = '0;
            slot_artist[i] = '0;
            if (i < HOME_SLOTS || i + 1 >= STORE_ENTRIES)
                slot_link[i] = LINK_NULL;
            else
                slot_link[i] = 6'(i + 1);
        end
        free_head    = (HOME_SLOTS < STORE_ENTRIES) ? 6'(HOME_SLOTS) : LINK_NULL;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = REQ_INSERT;
        i_genre_code = '0;
        i_title_id   = '0;
        i_artist_id  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_full_bucket();
        test_random_traffic(230, 27, 81);
        test_random_traffic(230, 81, 27);
        test_random_traffic(230, 0, 0);
        test_output_holdoff();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
